[sv/lmn_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmn_pkg: shared types and codes of the mutex node
// Mode and send codes, register indexes, sequencer states.
// ---------------------------------------------------------------------------
package lmn_pkg;

    // Lamport clock width, fixed by the stream layout
    localparam int unsigned CLOCK_BITS = 32;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOUSE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FENCE_COUNT = 2'd3;

    localparam logic [2:0] MODE_REQ_HOUSE  = 3'd0;
    localparam logic [2:0] MODE_REQ_FENCE  = 3'd1;
    localparam logic [2:0] MODE_RELEASE    = 3'd2;
    localparam logic [2:0] MODE_PEER_HOUSE = 3'd3;
    localparam logic [2:0] MODE_PEER_FENCE = 3'd4;
    localparam logic [2:0] MODE_FENCE_ACK  = 3'd5;
    localparam logic [2:0] MODE_HOUSE_ACK  = 3'd6;
    localparam logic [2:0] MODE_FINISH     = 3'd7;

    localparam logic [2:0] SEND_NONE        = 3'd0;
    localparam logic [2:0] SEND_BCAST_HOUSE = 3'd1;
    localparam logic [2:0] SEND_BCAST_FENCE = 3'd2;
    localparam logic [2:0] SEND_BCAST_DONE  = 3'd3;
    localparam logic [2:0] SEND_HOUSE_ACK   = 3'd4;
    localparam logic [2:0] SEND_FENCE_ACK   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_UPDATE,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

[sv/lmn_order_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmn_order_unit: shared (time, id) comparator
// One wide compare; reused by every scan step of the sequencer.
// ---------------------------------------------------------------------------
module lmn_order_unit #(
    parameter int unsigned CLOCK_BITS = 32,
    parameter int unsigned ID_W       = 4
) (
    input  logic [CLOCK_BITS-1:0] i_t1,
    input  logic [ID_W-1:0]       i_i1,
    input  logic [CLOCK_BITS-1:0] i_t2,
    input  logic [ID_W-1:0]       i_i2,
    output logic                  o_before
);
    // (t1,i1) strictly before (t2,i2)
    assign o_before = (i_t1 < i_t2) || ((i_t1 == i_t2) && (i_i1 < i_i2));
endmodule

[sv/lamport_multi_resource_mutex_node.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lamport_multi_resource_mutex_node: one node of a Lamport mutex group
//
//  channel   | dir | handshake          | payload
//  s_axis    | in  | tvalid/tready      | tdata: mode, peer_id, time, house, rechoose
//  m_axis    | out | tvalid/tready      | tdata: kind, target, time, house, grants
//  cfg       | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// From accept to result valid the node runs the shortest-queue pick, an update
// step, the grant scan and an output step. The pick walks every entry once per
// effective house on a resource request with rechoose, else it passes through.
// The grant scan does a house and a slot compare per entry (one shared unit).
// Reset is synchronous; the input side stays not ready until the result beat
// is taken (ready from the next cycle), the output beat holds while stalled.
// ---------------------------------------------------------------------------
module lamport_multi_resource_mutex_node
    import lmn_pkg::*;
#(
    parameter int unsigned MAX_NODES  = 16,
    parameter int unsigned MAX_HOUSES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // mode[2:0], peer_id[6:3], peer_time[38:7], peer_house[41:39], rechoose[42]
    input  logic [47:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // send_kind[2:0], send_target[6:3], send_time[38:7], send_house[41:39],
    // house_granted[42], fence_granted[43]
    output logic [47:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned TD   = 16;
    localparam int unsigned NMAX = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int unsigned HD   = (MAX_HOUSES < 8) ? MAX_HOUSES : 8;
    localparam int unsigned NW   = $clog2(TD);
    localparam logic [CLOCK_BITS-1:0] CMAX = '1;

    // configuration
    logic [4:0] r_node_count, r_fence_count;
    logic [3:0] r_own_id, r_house_count;

    logic [4:0] w_ne;
    logic [3:0] w_he;
    assign w_ne = (r_node_count == 5'd0) ? 5'd1 :
                  (r_node_count > 5'(NMAX)) ? 5'(NMAX) : r_node_count;
    assign w_he = (r_house_count == 4'd0) ? 4'd1 :
                  (r_house_count > 4'(HD)) ? 4'(HD) : r_house_count;

    // state
    t_state r_st, n_st;
    logic [CLOCK_BITS-1:0] r_clk_v;
    logic r_hwait, r_fwait;
    logic [2:0] r_chosen;
    logic [TD-1:0] r_hval, r_fval;
    logic [2:0] r_hidx [TD];
    logic [CLOCK_BITS-1:0] r_htime [TD];
    logic [CLOCK_BITS-1:0] r_ftime [TD];
    logic [TD-1:0] r_hidle, r_fidle;

    // latched event
    logic [2:0] r_mode, r_phouse;
    logic [3:0] r_peer;
    logic [CLOCK_BITS-1:0] r_ptime;
    logic r_rech;

    // scan registers
    logic [NW-1:0] r_i;
    logic [2:0] r_h;
    logic [4:0] r_len, r_best_len, r_htot, r_ftot, r_ahead;
    logic [2:0] r_best;
    logic r_have;
    logic [NW-1:0] r_head;
    logic [2:0] r_kind;
    logic [3:0] r_tgt;
    logic [CLOCK_BITS-1:0] r_stime;
    logic [2:0] r_shouse;
    logic r_out_v;
    logic [47:0] r_out;

    logic [NW-1:0] w_me;
    assign w_me = NW'(r_own_id);

    // shared comparator
    logic [CLOCK_BITS-1:0] w_t1, w_t2;
    logic [NW-1:0] w_i1, w_i2;
    logic w_before;
    lmn_order_unit #(.CLOCK_BITS(CLOCK_BITS), .ID_W(NW)) u_ord (
        .i_t1(w_t1), .i_i1(w_i1), .i_t2(w_t2), .i_i2(w_i2), .o_before(w_before)
    );
    always_comb begin
        if (r_st == ST_SCAN && r_h == '0) begin
            w_t1 = r_htime[r_i]; w_i1 = r_i; w_t2 = r_htime[r_head]; w_i2 = r_head;
        end else begin
            w_t1 = r_ftime[r_i]; w_i1 = r_i; w_t2 = r_ftime[w_me]; w_i2 = w_me;
        end
    end

    function automatic logic [CLOCK_BITS-1:0] sat_inc(input logic [CLOCK_BITS-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    // x mod d for a 4-bit x and d in 1..8: four compare-and-subtract steps
    function automatic logic [2:0] small_mod(input logic [3:0] x, input logic [3:0] d);
        logic [6:0] rem;
        rem = {3'b0, x};
        for (int s = 3; s >= 0; s--) begin
            if (rem >= ({3'b0, d} << s)) rem = rem - ({3'b0, d} << s);
        end
        return rem[2:0];
    endfunction

    logic [CLOCK_BITS-1:0] w_ptime;
    assign w_ptime = s_axis_tdata[7 +: CLOCK_BITS];

    logic w_last_i;
    assign w_last_i = (r_i == NW'(TD - 1));
    logic w_peer_ok;
    assign w_peer_ok = (r_peer != r_own_id) && ({1'b0, r_peer} < w_ne) &&
                       !(r_mode == MODE_PEER_HOUSE && {1'b0, r_phouse} >= w_he);

    assign s_axis_tready = (r_st == ST_IDLE) && !r_out_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (s_axis_tvalid && s_axis_tready) n_st = ST_PICK;
            ST_PICK: begin
                if (!(r_mode == MODE_REQ_HOUSE && r_rech)) n_st = ST_UPDATE;
                else if (w_last_i && r_h == 3'(w_he - 4'd1)) n_st = ST_UPDATE;
            end
            ST_UPDATE: n_st = ST_SCAN;
            ST_SCAN:   if (w_last_i && r_h != '0) n_st = ST_OUT;
            ST_OUT:    n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_node_count <= 5'd1; r_own_id <= '0; r_house_count <= 4'd1;
            r_fence_count <= 5'd1; r_chosen <= '0;
            r_clk_v <= '0; r_hwait <= 1'b0; r_fwait <= 1'b0;
            r_hval <= '0; r_fval <= '0; r_hidle <= '0; r_fidle <= '0;
            r_out_v <= 1'b0; r_i <= '0; r_h <= '0;
        end else begin
            r_st <= n_st;
            if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            // configuration
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NODE_COUNT:  r_node_count <= i_cfg_data;
                    REG_OWN_ID: begin
                        r_own_id <= i_cfg_data[3:0];
                        r_chosen <= small_mod(i_cfg_data[3:0], w_he);
                    end
                    REG_HOUSE_COUNT: begin
                        r_house_count <= i_cfg_data[3:0];
                        r_chosen <= small_mod(r_own_id, (i_cfg_data[3:0] == 4'd0) ? 4'd1 :
                                   (i_cfg_data[3:0] > 4'(HD)) ? 4'(HD) : i_cfg_data[3:0]);
                    end
                    REG_FENCE_COUNT: r_fence_count <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: begin
                    r_mode <= s_axis_tdata[2:0]; r_peer <= s_axis_tdata[6:3];
                    r_ptime <= w_ptime;
                    r_phouse <= s_axis_tdata[39 + CLOCK_BITS - 32 +: 3];
                    r_rech <= s_axis_tdata[42 + CLOCK_BITS - 32];
                    r_i <= '0; r_h <= '0; r_len <= '0; r_best <= '0; r_best_len <= '0;
                end
                // one entry per cycle, house by house
                ST_PICK: if (r_mode == MODE_REQ_HOUSE && r_rech) begin
                    logic [4:0] len;
                    len = r_len + 5'(r_hval[r_i] && r_hidx[r_i] == r_h);
                    r_i <= r_i + 1'b1;
                    if (w_last_i) begin
                        if (r_h == '0 || len < r_best_len) begin
                            r_best_len <= len; r_best <= r_h;
                            if (r_h == 3'(w_he - 4'd1)) r_chosen <= r_h;
                        end else if (r_h == 3'(w_he - 4'd1)) r_chosen <= r_best;
                        r_h <= r_h + 1'b1; r_len <= '0;
                    end else r_len <= len;
                end
                ST_UPDATE: begin
                    logic [2:0] k, sh;
                    logic [3:0] tg;
                    logic [CLOCK_BITS-1:0] c, st, m;
                    logic [TD-1:0] hi, fi;
                    k = SEND_NONE; tg = '0; st = '0; sh = '0;
                    c = r_clk_v; hi = r_hidle; fi = r_fidle;
                    r_i <= '0; r_h <= '0; r_have <= 1'b0; r_head <= '0;
                    r_ahead <= '0;
                    if (r_mode == MODE_REQ_HOUSE) begin
                        c = sat_inc(c); r_hwait <= 1'b1;
                        r_hval[w_me] <= 1'b1; r_hidx[w_me] <= r_chosen;
                        r_htime[w_me] <= c; hi = '0;
                        k = SEND_BCAST_HOUSE; st = c; sh = r_chosen;
                    end else if (r_mode == MODE_REQ_FENCE) begin
                        c = sat_inc(c); r_fwait <= 1'b1;
                        r_fval[w_me] <= 1'b1; r_ftime[w_me] <= c; fi = '0;
                        k = SEND_BCAST_FENCE; st = c;
                    end else if (r_mode == MODE_RELEASE) begin
                        c = sat_inc(c); r_hwait <= 1'b0; r_fwait <= 1'b0;
                        r_hval[w_me] <= 1'b0; r_fval[w_me] <= 1'b0;
                        k = SEND_BCAST_DONE; st = c; sh = r_chosen;
                    end else if (w_peer_ok) begin
                        unique case (r_mode)
                            MODE_PEER_HOUSE: begin
                                hi[r_peer[NW-1:0]] = 1'b0;
                                r_hval[r_peer[NW-1:0]] <= 1'b1;
                                r_hidx[r_peer[NW-1:0]] <= r_phouse;
                                r_htime[r_peer[NW-1:0]] <= r_ptime;
                                if (!r_hwait) begin
                                    c = sat_inc(c); k = SEND_HOUSE_ACK;
                                    tg = r_peer; st = c;
                                end
                            end
                            MODE_PEER_FENCE: begin
                                fi[r_peer[NW-1:0]] = 1'b0;
                                r_fval[r_peer[NW-1:0]] <= 1'b1;
                                r_ftime[r_peer[NW-1:0]] <= r_ptime;
                                if (!r_fwait) begin
                                    c = sat_inc(c); k = SEND_FENCE_ACK;
                                    tg = r_peer; st = c;
                                end
                            end
                            MODE_FENCE_ACK: fi[r_peer[NW-1:0]] = 1'b1;
                            MODE_HOUSE_ACK: hi[r_peer[NW-1:0]] = 1'b1;
                            default: begin
                                hi[r_peer[NW-1:0]] = 1'b1; fi[r_peer[NW-1:0]] = 1'b1;
                                r_hval[r_peer[NW-1:0]] <= 1'b0;
                                r_fval[r_peer[NW-1:0]] <= 1'b0;
                            end
                        endcase
                        m = (r_ptime > c) ? r_ptime : c;
                        c = sat_inc(m);
                    end
                    r_clk_v <= c;
                    r_hidle <= hi; r_fidle <= fi;
                    r_htot <= 5'($countones(hi)); r_ftot <= 5'($countones(fi));
                    r_kind <= k; r_tgt <= tg; r_stime <= st; r_shouse <= sh;
                end
                // grant scan, house step then slot step per entry: both share the unit
                ST_SCAN: begin
                    if (r_h == '0) begin
                        if (r_hval[r_i] && {1'b0, r_hidx[r_i]} < w_he) begin
                            r_htot <= r_htot + 5'd1;
                            if (r_hidx[r_i] == r_chosen && (!r_have || w_before)) begin
                                r_head <= r_i; r_have <= 1'b1;
                            end
                        end
                        r_h <= 3'd1;
                    end else begin
                        if (r_fval[r_i]) begin
                            r_ftot <= r_ftot + 5'd1;
                            if (r_i != w_me && w_before) r_ahead <= r_ahead + 5'd1;
                        end
                        r_h <= '0; r_i <= r_i + 1'b1;
                    end
                end
                ST_OUT: begin
                    r_out_v <= 1'b1;
                    r_out <= {4'b0,
                              (r_ftot == w_ne) && r_fval[w_me] && (r_ahead < r_fence_count),
                              (r_htot == w_ne) && r_have && (r_head == w_me),
                              r_shouse, r_stime, r_tgt, r_kind};
                end
                default: ;
            endcase
        end
    end
endmodule

[sv/lmn_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmn_checker: port-level checks of the mutex node
// Watches the stream ports; bound to the top level.
// ---------------------------------------------------------------------------
module lmn_checker
    import lmn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // no new beat accepted while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
    // a result follows acceptance only later
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");
    // every result beat has a kind code in range
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= SEND_FENCE_ACK)) else $error("bad kind");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
endmodule

bind lamport_multi_resource_mutex_node lmn_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

[tb/sv/tb_lamport_multi_resource_mutex_node.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lamport_multi_resource_mutex_node: self-checking bench of the mutex node
// Drives local commands and peer messages over the input stream, predicts
// every result beat with a local model of the node, and compares field by
// field. Runs several register settings, most with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_lamport_multi_resource_mutex_node;
    import lmn_pkg::*;

    localparam int unsigned NODES = 16;
    localparam logic [31:0] CLK_TOP = 32'hffff_ffff;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  target;
        logic [31:0] stamp;
        logic [2:0]  house;
        logic        hgrant;
        logic        fgrant;
    } t_result;

    typedef struct {
        logic [2:0]  mode;
        logic [3:0]  peer;
        logic [31:0] ptime;
        logic [2:0]  phouse;
        logic        rech;
        bit          known;
        t_result     res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // mode, peer_id, peer_time, peer_house, rechoose
    logic [47:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // send_kind, send_target, send_time, send_house, house_granted, fence_granted
    logic [47:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lamport_multi_resource_mutex_node dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("lamport_multi_resource_mutex_node test failed");
        $finish;
    end

    // node mirror
    logic [4:0]  cfg_nodes, cfg_fences;
    logic [3:0]  cfg_me, cfg_houses;
    logic [31:0] lclock;
    bit          h_wait, f_wait;
    logic [2:0]  pick;
    bit          hv [NODES];
    logic [2:0]  hidx [NODES];
    logic [31:0] ht [NODES];
    bit          fv [NODES];
    logic [31:0] ft [NODES];
    logic [15:0] h_idle, f_idle;

    t_result     expected_beats[$];
    int          errors = 0;
    bit          rx_idle_on = 1'b1;

    function automatic int n_eff();
        return (cfg_nodes < 1) ? 1 : (cfg_nodes > NODES ? NODES : int'(cfg_nodes));
    endfunction

    function automatic int h_eff();
        return (cfg_houses < 1) ? 1 : (cfg_houses > 8 ? 8 : int'(cfg_houses));
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == CLK_TOP) ? v : v + 1;
    endfunction

    function automatic bit earlier(logic [31:0] t1, int i1, logic [31:0] t2, int i2);
        return t1 < t2 || (t1 == t2 && i1 < i2);
    endfunction

    function automatic void mirror_reset();
        cfg_nodes = 1; cfg_me = 0; cfg_houses = 1; cfg_fences = 1;
        lclock = 0; h_wait = 0; f_wait = 0; h_idle = 0; f_idle = 0;
        for (int i = 0; i < NODES; i++) begin
            hv[i] = 0; fv[i] = 0; hidx[i] = 0; ht[i] = 0; ft[i] = 0;
        end
        pick = 0;
    endfunction

    function automatic void mirror_config(logic [1:0] idx, logic [4:0] val);
        case (idx)
            REG_NODE_COUNT:  cfg_nodes = val;
            REG_OWN_ID:      cfg_me = val[3:0];
            REG_HOUSE_COUNT: cfg_houses = val[3:0];
            default:         cfg_fences = val;
        endcase
        if (idx == REG_OWN_ID || idx == REG_HOUSE_COUNT) pick = 3'(int'(cfg_me) % h_eff());
    endfunction

    function automatic bit house_ok();
        int total, head;
        bit have;
        total = $countones(h_idle); head = 0; have = 0;
        for (int i = 0; i < NODES; i++) begin
            if (!hv[i] || hidx[i] >= h_eff()) continue;
            total++;
            if (hidx[i] == pick && (!have || earlier(ht[i], i, ht[head], head))) begin
                head = i; have = 1;
            end
        end
        return total == n_eff() && have && head == cfg_me;
    endfunction

    function automatic bit fence_ok();
        int total, ahead;
        total = $countones(f_idle); ahead = 0;
        for (int i = 0; i < NODES; i++) begin
            if (!fv[i]) continue;
            total++;
            if (i != cfg_me && earlier(ft[i], i, ft[cfg_me], cfg_me)) ahead++;
        end
        return total == n_eff() && fv[cfg_me] && ahead < cfg_fences;
    endfunction

    // applies one event to the mirror and returns the beat it causes
    function automatic t_result node_event(logic [2:0] mode, logic [3:0] peer,
                                           logic [31:0] ptime, logic [2:0] phouse, bit rech);
        t_result r;
        int me, best, best_len, len;
        me = cfg_me;
        r = '0;
        if (mode <= MODE_RELEASE) begin
            lclock = bump(lclock);
            if (mode == MODE_REQ_HOUSE) begin
                if (rech) begin
                    best = 0; best_len = 0;
                    for (int h = 0; h < h_eff(); h++) begin
                        len = 0;
                        for (int i = 0; i < NODES; i++) if (hv[i] && hidx[i] == h) len++;
                        if (h == 0 || len < best_len) begin best_len = len; best = h; end
                    end
                    pick = 3'(best);
                end
                h_wait = 1; hv[me] = 1; hidx[me] = pick; ht[me] = lclock; h_idle = 0;
                r.kind = SEND_BCAST_HOUSE; r.stamp = lclock; r.house = pick;
            end else if (mode == MODE_REQ_FENCE) begin
                f_wait = 1; fv[me] = 1; ft[me] = lclock; f_idle = 0;
                r.kind = SEND_BCAST_FENCE; r.stamp = lclock;
            end else begin
                f_wait = 0; fv[me] = 0; h_wait = 0; hv[me] = 0;
                r.kind = SEND_BCAST_DONE; r.stamp = lclock; r.house = pick;
            end
        end else if (peer != cfg_me && peer < n_eff() &&
                     !(mode == MODE_PEER_HOUSE && phouse >= h_eff())) begin
            case (mode)
                MODE_PEER_HOUSE: begin
                    h_idle[peer] = 0; hv[peer] = 1; hidx[peer] = phouse; ht[peer] = ptime;
                    if (!h_wait) begin
                        lclock = bump(lclock);
                        r.kind = SEND_HOUSE_ACK; r.target = peer; r.stamp = lclock;
                    end
                end
                MODE_PEER_FENCE: begin
                    fv[peer] = 1; ft[peer] = ptime; f_idle[peer] = 0;
                    if (!f_wait) begin
                        lclock = bump(lclock);
                        r.kind = SEND_FENCE_ACK; r.target = peer; r.stamp = lclock;
                    end
                end
                MODE_FENCE_ACK: f_idle[peer] = 1;
                MODE_HOUSE_ACK: h_idle[peer] = 1;
                default: begin
                    hv[peer] = 0; fv[peer] = 0; h_idle[peer] = 1; f_idle[peer] = 1;
                end
            endcase
            lclock = bump(ptime > lclock ? ptime : lclock);
        end
        r.hgrant = house_ok();
        r.fgrant = fence_ok();
        return r;
    endfunction

    task automatic idle_gap();
        repeat ($urandom_range(1, 13)) @(negedge i_clk);
    endtask

    // holds valid across back-to-back beats; drops it only for a gap
    task automatic send_event(logic [2:0] mode, logic [3:0] peer, logic [31:0] ptime,
                              logic [2:0] phouse, bit rech, bit idle_on);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            idle_gap();
        end
        s_axis_tdata <= {5'b0, rech, phouse, ptime, peer, mode};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_beats = {expected_beats, node_event(mode, peer, ptime, phouse, rech)};
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        mirror_config(idx, val);
    endtask

    task automatic setup(int n, int me, int h, int f);
        write_reg(REG_NODE_COUNT, 5'(n));
        write_reg(REG_OWN_ID, 5'(me));
        write_reg(REG_HOUSE_COUNT, 5'(h));
        write_reg(REG_FENCE_COUNT, 5'(f));
        i_cfg_we <= 1'b0;
    endtask

    // receiver: random stalls, compare against the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.kind   = m_axis_tdata[2:0];
            got.target = m_axis_tdata[6:3];
            got.stamp  = m_axis_tdata[38:7];
            got.house  = m_axis_tdata[41:39];
            got.hgrant = m_axis_tdata[42];
            got.fgrant = m_axis_tdata[43];
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind) begin
                    $error("send_kind exp %0d got %0d", want.kind, got.kind); errors++; end
                if (got.target !== want.target) begin
                    $error("send_target exp %0d got %0d", want.target, got.target); errors++; end
                if (got.stamp !== want.stamp) begin
                    $error("send_time exp %h got %h", want.stamp, got.stamp); errors++; end
                if (got.house !== want.house) begin
                    $error("send_house exp %0d got %0d", want.house, got.house); errors++; end
                if (got.hgrant !== want.hgrant) begin
                    $error("house_granted exp %0d got %0d", want.hgrant, got.hgrant); errors++; end
                if (got.fgrant !== want.fgrant) begin
                    $error("fence_granted exp %0d got %0d", want.fgrant, got.fgrant); errors++; end
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one random event, mostly well-formed protocol traffic for a live group
    task automatic random_event(bit idle_on);
        logic [2:0] mode;
        logic [3:0] peer;
        logic [31:0] pt;
        int sel;
        mode = 3'($urandom_range(0, 7));
        sel = $urandom_range(0, 19);
        if (sel < 17) peer = 4'($urandom_range(0, n_eff() - 1));
        else peer = 4'($urandom);
        case ($urandom_range(0, 9))
            0: pt = CLK_TOP - $urandom_range(0, 3);
            1: pt = $urandom;
            2: pt = 0;
            default: pt = lclock + $urandom_range(0, 6) - 3;
        endcase
        send_event(mode, peer, pt, 3'($urandom_range(0, 7)), $urandom_range(0, 1), idle_on);
    endtask

    // directed rows; known results only where obvious
    t_row dir_rows[$];

    // walks the row table; typed results are checked against the prediction
    task automatic run_rows(bit idle_on);
        foreach (dir_rows[k]) begin
            send_event(dir_rows[k].mode, dir_rows[k].peer, dir_rows[k].ptime,
                       dir_rows[k].phouse, dir_rows[k].rech, idle_on);
            if (dir_rows[k].known && expected_beats[$] !== dir_rows[k].res) begin
                $error("directed row %0d prediction mismatch", k); errors++;
            end
        end
    endtask

    initial begin
        t_row row;
        mirror_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: single node, request and release
        row = '{MODE_REQ_HOUSE, 0, 0, 0, 0, 1, '{SEND_BCAST_HOUSE, 0, 1, 0, 1, 0}};
        dir_rows = {dir_rows, row};
        row = '{MODE_REQ_FENCE, 0, 0, 0, 0, 1, '{SEND_BCAST_FENCE, 0, 2, 0, 1, 1}};
        dir_rows = {dir_rows, row};
        row = '{MODE_RELEASE, 0, 0, 0, 0, 1, '{SEND_BCAST_DONE, 0, 3, 0, 0, 0}};
        dir_rows = {dir_rows, row};
        // message from own id is ignored
        row = '{MODE_PEER_HOUSE, 0, 32'h100, 0, 0, 1, '{SEND_NONE, 0, 0, 0, 0, 0}};
        dir_rows = {dir_rows, row};
        run_rows(1'b0);
        drain();

        // four nodes, three houses: peers, bad sender, bad house, saturation
        setup(4, 2, 3, 2);
        dir_rows.delete();
        row = '{MODE_PEER_HOUSE, 1, 32'h5, 1, 0, 0, '0};           dir_rows = {dir_rows, row};
        row = '{MODE_PEER_HOUSE, 3, 32'h7, 5, 0, 0, '0};           dir_rows = {dir_rows, row};
        row = '{MODE_PEER_FENCE, 9, 32'h7, 0, 0, 0, '0};           dir_rows = {dir_rows, row};
        row = '{MODE_PEER_FENCE, 0, 32'h3, 0, 0, 0, '0};           dir_rows = {dir_rows, row};
        row = '{MODE_REQ_HOUSE, 0, 0, 0, 1, 0, '0};                dir_rows = {dir_rows, row};
        row = '{MODE_REQ_FENCE, 0, 0, 0, 0, 0, '0};                dir_rows = {dir_rows, row};
        row = '{MODE_HOUSE_ACK, 0, 32'h1, 0, 0, 0, '0};            dir_rows = {dir_rows, row};
        row = '{MODE_HOUSE_ACK, 3, 32'h1, 0, 0, 0, '0};            dir_rows = {dir_rows, row};
        row = '{MODE_FENCE_ACK, 3, 32'h1, 0, 0, 0, '0};            dir_rows = {dir_rows, row};
        row = '{MODE_PEER_HOUSE, 1, 32'h8, 2, 0, 0, '0};           dir_rows = {dir_rows, row};
        row = '{MODE_FINISH, 1, 32'h9, 7, 0, 0, '0};               dir_rows = {dir_rows, row};
        row = '{MODE_PEER_FENCE, 3, CLK_TOP, 7, 1, 0, '0};         dir_rows = {dir_rows, row};
        row = '{MODE_REQ_HOUSE, 15, CLK_TOP, 7, 1, 0, '0};         dir_rows = {dir_rows, row};
        row = '{MODE_FINISH, 0, CLK_TOP, 0, 0, 0, '0};             dir_rows = {dir_rows, row};
        row = '{MODE_RELEASE, 0, 0, 0, 0, 0, '0};                  dir_rows = {dir_rows, row};
        run_rows(1'b1);
        drain();

        // random phases across settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: setup(16, 15, 8, 16);
                1: setup(2, 0, 1, 1);
                2: setup(0, 0, 0, 0);
                3: setup(31, 7, 15, 31);
                4: setup(5, 4, 2, 3);
                default: setup($urandom_range(1, 16), $urandom_range(0, 15),
                               $urandom_range(1, 8), $urandom_range(1, 16));
            endcase
            if (ph == 7) rx_idle_on = 1'b0;
            for (int n = 0; n < 125; n++) begin
                random_event(ph != 7);
                // hold off until everything is back, once
                if (ph == 4 && n == 60) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_beats.size() != 0) @(negedge i_clk);
                    @(negedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("lamport_multi_resource_mutex_node test passed");
        else
            $display("lamport_multi_resource_mutex_node test failed");
        $finish;
    end
endmodule
